// File: hw/rtl/binary_tophat_filter_unit_defines.svh
// Assertion macros used by the filter RTL.
`ifndef BINARY_TOPHAT_FILTER_UNIT_DEFINES_SVH
`define BINARY_TOPHAT_FILTER_UNIT_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define BTF_ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Check that post holds in the cycle after pre.
`define BTF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: hw/rtl/btf_pkg.sv
// Shared types and constants of the binary top-hat filter.
package btf_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

	// Per-word classification made by the front end
	typedef struct packed {
		logic first;  // first word of a frame
		logic c1v;    // erosion center lies at or after the frame origin
		logic emit;   // word produces an output pixel
		logic last;   // word produces the final pixel of the frame
	} btf_flags_t;

endpackage

// File: hw/rtl/btf_ram.sv
// Generic simple dual-port RAM with registered read.
module btf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/btf_fifo.sv
// Short register queue between front end and back end.
module btf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data,
	input  logic             pop
);

	localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTW-1:0]   wr_q;
	logic [PTW-1:0]   rd_q;
	logic [CNW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTW'(DEPTH - 1)) ? '0 : wr_q + PTW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTW'(DEPTH - 1)) ? '0 : rd_q + PTW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/btf_front.sv
// Front end: configuration registers, frame latch and word classification.
module btf_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [btf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [btf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [btf_pkg::PIX_W-1:0]             s_tdata,
	input  logic                                  s_tuser,
	input  logic                                  push_ready,
	output logic                                  push_valid,
	output btf_pkg::btf_flags_t                   push_flags,
	output logic [btf_pkg::PIX_W-1:0]             push_px,
	output logic [$clog2(MAX_WIDTH+1)-1:0]        push_w,
	output logic [$clog2(MAX_HEIGHT+1)-1:0]       push_h,
	output logic [$clog2((((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW) / 2 + 1)-1:0]
	                                              push_r
);

	import btf_pkg::*;

	localparam int MWO   = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
	localparam int RMAX  = (MWO - 1) / 2;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(RMAX + 1);
	localparam int IPW   = $clog2(MAX_WIDTH * (MAX_HEIGHT + 4 * RMAX + 2));
	localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	logic [WW-1:0]    cfg_w_q;
	logic [HW-1:0]    cfg_h_q;
	logic [RW-1:0]    cfg_r_q;
	logic [WW-1:0]    lat_w_q;
	logic [HW-1:0]    lat_h_q;
	logic [RW-1:0]    lat_r_q;
	logic [IPW-1:0]   lat_s1_q;
	logic [IPW-1:0]   lat_d_q;
	logic [IPW-1:0]   lat_tot_q;
	logic [IPW-1:0]   lat_end_q;
	logic [IPW-1:0]   pos_q;

	logic [WW-1:0]    w_new;
	logic [HW-1:0]    h_new;
	logic [RW-1:0]    r_new;
	logic [3:0]       ws_odd;
	logic [RW+WW-1:0] rw_prod;
	logic [WW+HW-1:0] tot_prod;
	logic [IPW-1:0]   s1_new;
	logic [IPW-1:0]   d_new;
	logic [IPW-1:0]   end_new;
	logic             first;
	logic             in_img;
	logic             accept;

	// Clamp written values to the supported ranges
	always_comb begin
		w_new = (cfg_wdata == '0) ? WW'(1) :
			((int'(cfg_wdata) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_wdata));
		h_new = (cfg_wdata == '0) ? HW'(1) :
			((int'(cfg_wdata) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata));
		if (cfg_wdata[2:0] == 3'd0) begin
			ws_odd = 4'd1;
		end else if (cfg_wdata[0]) begin
			ws_odd = {1'b0, cfg_wdata[2:0]};
		end else begin
			ws_odd = {1'b0, cfg_wdata[2:0]} - 4'd1;
		end
		if (int'(ws_odd) > MWO) begin
			ws_odd = 4'(MWO);
		end
		r_new = RW'((ws_odd - 4'd1) >> 1);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= WW'(W_RST);
			cfg_h_q <= HW'(H_RST);
			cfg_r_q <= RW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_w_q <= w_new;
				REG_IMAGE_HEIGHT: cfg_h_q <= h_new;
				REG_WINDOW_SIZE:  cfg_r_q <= r_new;
				default: ;
			endcase
		end
	end

	// Frame geometry from the current registers
	always_comb begin
		rw_prod  = cfg_r_q * cfg_w_q;
		tot_prod = cfg_w_q * cfg_h_q;
		s1_new   = IPW'(rw_prod) + IPW'(cfg_r_q);
		d_new    = s1_new << 1;
		end_new  = IPW'(tot_prod) + d_new - IPW'(1);
	end

	// Classify the word at the head of the input
	always_comb begin
		first      = (pos_q == '0);
		push_flags = '0;
		if (first) begin
			push_w           = cfg_w_q;
			push_h           = cfg_h_q;
			push_r           = cfg_r_q;
			in_img           = 1'b1;
			push_flags.c1v   = (cfg_r_q == '0);
			push_flags.emit  = (cfg_r_q == '0);
			push_flags.last  = (cfg_r_q == '0) && (cfg_w_q == WW'(1)) && (cfg_h_q == HW'(1));
		end else begin
			push_w           = lat_w_q;
			push_h           = lat_h_q;
			push_r           = lat_r_q;
			in_img           = (pos_q < lat_tot_q);
			push_flags.c1v   = (pos_q >= lat_s1_q);
			push_flags.emit  = (pos_q >= lat_d_q);
			push_flags.last  = (pos_q == lat_end_q);
		end
		push_flags.first = first;
		push_px          = (in_img && !s_tuser) ? s_tdata : '0;
	end

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;
	assign accept     = s_tvalid && push_ready;

	// Latch the geometry at the first word of a frame
	always_ff @(posedge clk) begin
		if (accept && first) begin
			lat_s1_q  <= s1_new;
			lat_d_q   <= d_new;
			lat_tot_q <= IPW'(tot_prod);
			lat_end_q <= end_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_w_q <= WW'(W_RST);
			lat_h_q <= HW'(H_RST);
			lat_r_q <= RW'(1);
			pos_q   <= '0;
		end else if (accept) begin
			if (first) begin
				lat_w_q <= cfg_w_q;
				lat_h_q <= cfg_h_q;
				lat_r_q <= cfg_r_q;
			end
			pos_q <= push_flags.last ? '0 : pos_q + IPW'(1);
		end
	end

endmodule

// File: hw/rtl/btf_back.sv
// Back end: line-buffered erosion and dilation windows and the output register.
`include "binary_tophat_filter_unit_defines.svh"

module btf_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  head_valid,
	input  btf_pkg::btf_flags_t                   head_flags,
	input  logic [btf_pkg::PIX_W-1:0]             head_px,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]        head_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]       head_h,
	input  logic [$clog2((((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW) / 2 + 1)-1:0]
	                                              head_r,
	output logic                                  pop,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [btf_pkg::PIX_W-1:0]             m_tdata,
	output logic                                  m_tlast
);

	import btf_pkg::*;

	localparam int MWO  = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
	localparam int RMAX = (MWO - 1) / 2;
	localparam int TAPS = 2 * RMAX + 1;
	localparam int LBR  = 2 * RMAX;
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int RW   = $clog2(RMAX + 1);
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int YW   = $clog2(MAX_HEIGHT + 4 * RMAX + 4) + 1;
	localparam int YSW  = YW + 2;
	localparam int XSW  = WW + 2;
	localparam int TIW  = $clog2(TAPS);
	localparam int SIW  = $clog2(LBR);
	localparam int BW   = PIX_W + 1;

	logic             adv;
	logic [AW-1:0]    k_q;
	logic [AW-1:0]    k_cur;
	logic [AW-1:0]    k_next;
	logic [WW-1:0]    k_inc;
	logic             w_one;
	logic [SIW-1:0]   rm1;

	logic [LBR*PIX_W-1:0] rd1, lb1, wr1, lw1_q;
	logic [LBR*BW-1:0]    rd2, lb2, wr2, lw2_q;
	logic [PIX_W-1:0]     col1 [TAPS];
	logic [BW-1:0]        col2 [TAPS];
	logic [TAPS-1:0]      win1 [TAPS];
	logic [TAPS-1:0]      win2 [TAPS];
	logic [LBR-1:0]       sh1_q [TAPS];
	logic [LBR-1:0]       sh2_q [TAPS];
	logic [PIX_W-1:0]     sb1_q [LBR];
	logic [PIX_W-1:0]     sb2_q [LBR];
	logic [PIX_W-1:0]     cb1, cb2, b1, orig;

	logic [YW-1:0]    cy1_q, cy2_q, cy1, cy2, cy1_n, cy2_n;
	logic [AW-1:0]    cx1_q, cx2_q, cx1, cx2, cx1_n, cx2_n;
	logic [TAPS-1:0]  rowv1, colv1, rowv2, colv2;
	logic signed [YSW-1:0] ry;
	logic signed [XSW-1:0] rx;
	logic             e1;
	logic             opened;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_data_q;
	logic             out_last_q;

	assign adv   = head_valid && (!out_valid_q || m_tready);
	assign pop   = adv;
	assign w_one = (head_w == WW'(1));
	assign rm1   = SIW'(head_r) - SIW'(1);

	// Ring position of this word within the row buffers
	always_comb begin
		k_cur  = head_flags.first ? '0 : k_q;
		k_inc  = WW'(k_cur) + WW'(1);
		k_next = (k_inc == head_w) ? '0 : AW'(k_inc);
	end

	// Column of pixels for the erosion window
	always_comb begin
		lb1     = w_one ? lw1_q : rd1;
		col1[0] = head_px;
		for (int j = 1; j < TAPS; j++) begin
			col1[j] = lb1[(j-1)*PIX_W +: PIX_W];
		end
		for (int j = 0; j < LBR; j++) begin
			wr1[j*PIX_W +: PIX_W] = col1[j];
		end
		for (int j = 0; j < TAPS; j++) begin
			win1[j][0] = (col1[j] != '0);
			for (int i = 1; i < TAPS; i++) begin
				win1[j][i] = sh1_q[j][i-1];
			end
		end
		cb1 = col1[TIW'(head_r)];
		b1  = (head_r == '0) ? cb1 : sb1_q[rm1];
	end

	// Center coordinates of both windows
	always_comb begin
		cy1 = head_flags.first ? '0 : cy1_q;
		cx1 = head_flags.first ? '0 : cx1_q;
		cy2 = head_flags.first ? '0 : cy2_q;
		cx2 = head_flags.first ? '0 : cx2_q;
		if (WW'(cx1) + WW'(1) == head_w) begin
			cx1_n = '0;
			cy1_n = cy1 + YW'(1);
		end else begin
			cx1_n = cx1 + AW'(1);
			cy1_n = cy1;
		end
		if (WW'(cx2) + WW'(1) == head_w) begin
			cx2_n = '0;
			cy2_n = cy2 + YW'(1);
		end else begin
			cx2_n = cx2 + AW'(1);
			cy2_n = cy2;
		end
	end

	// Mask window taps that fall outside the image
	always_comb begin
		for (int j = 0; j < TAPS; j++) begin
			ry       = $signed(YSW'(cy1)) + $signed(YSW'(head_r)) - $signed(YSW'(j));
			rowv1[j] = (ry >= 0) && (ry < $signed(YSW'(head_h)));
			ry       = $signed(YSW'(cy2)) + $signed(YSW'(head_r)) - $signed(YSW'(j));
			rowv2[j] = (ry >= 0) && (ry < $signed(YSW'(head_h)));
			rx       = $signed(XSW'(cx1)) + $signed(XSW'(head_r)) - $signed(XSW'(j));
			colv1[j] = (rx >= 0) && (rx < $signed(XSW'(head_w)));
			rx       = $signed(XSW'(cx2)) + $signed(XSW'(head_r)) - $signed(XSW'(j));
			colv2[j] = (rx >= 0) && (rx < $signed(XSW'(head_w)));
		end
	end

	// Erode: every tap of the window set and inside the image
	always_comb begin
		e1 = head_flags.c1v;
		for (int j = 0; j < TAPS; j++) begin
			for (int i = 0; i < TAPS; i++) begin
				if (j <= 2 * int'(head_r) && i <= 2 * int'(head_r)) begin
					e1 = e1 & win1[j][i] & rowv1[j] & colv1[i];
				end
			end
		end
	end

	// Column of eroded bits and delayed pixels for the dilation window
	always_comb begin
		lb2     = w_one ? lw2_q : rd2;
		col2[0] = {e1, b1};
		for (int j = 1; j < TAPS; j++) begin
			col2[j] = lb2[(j-1)*BW +: BW];
		end
		for (int j = 0; j < LBR; j++) begin
			wr2[j*BW +: BW] = col2[j];
		end
		for (int j = 0; j < TAPS; j++) begin
			win2[j][0] = col2[j][BW-1];
			for (int i = 1; i < TAPS; i++) begin
				win2[j][i] = sh2_q[j][i-1];
			end
		end
		cb2  = col2[TIW'(head_r)][PIX_W-1:0];
		orig = (head_r == '0) ? cb2 : sb2_q[rm1];
	end

	// Dilate: any eroded tap inside the image
	always_comb begin
		opened = 1'b0;
		for (int j = 0; j < TAPS; j++) begin
			for (int i = 0; i < TAPS; i++) begin
				if (j <= 2 * int'(head_r) && i <= 2 * int'(head_r)) begin
					opened = opened | (win2[j][i] & rowv2[j] & colv2[i]);
				end
			end
		end
	end

	btf_ram #(.WIDTH(LBR*PIX_W), .DEPTH(MAX_WIDTH)) u_lines_erode (
		.clk   (clk),
		.we    (adv),
		.waddr (k_cur),
		.wdata (wr1),
		.re    (adv),
		.raddr (k_next),
		.rdata (rd1)
	);

	btf_ram #(.WIDTH(LBR*BW), .DEPTH(MAX_WIDTH)) u_lines_dilate (
		.clk   (clk),
		.we    (adv),
		.waddr (k_cur),
		.wdata (wr2),
		.re    (adv),
		.raddr (k_next),
		.rdata (rd2)
	);

	// Shift window columns and hold the last written row word
	always_ff @(posedge clk) begin
		if (adv) begin
			lw1_q <= wr1;
			lw2_q <= wr2;
			for (int j = 0; j < TAPS; j++) begin
				sh1_q[j][0] <= win1[j][0];
				sh2_q[j][0] <= win2[j][0];
				for (int i = 1; i < LBR; i++) begin
					sh1_q[j][i] <= sh1_q[j][i-1];
					sh2_q[j][i] <= sh2_q[j][i-1];
				end
			end
			sb1_q[0] <= cb1;
			sb2_q[0] <= cb2;
			for (int i = 1; i < LBR; i++) begin
				sb1_q[i] <= sb1_q[i-1];
				sb2_q[i] <= sb2_q[i-1];
			end
		end
	end

	// Advance ring pointer and center counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			cy1_q <= '0;
			cx1_q <= '0;
			cy2_q <= '0;
			cx2_q <= '0;
		end else if (adv) begin
			k_q   <= k_next;
			cy1_q <= head_flags.c1v ? cy1_n : cy1;
			cx1_q <= head_flags.c1v ? cx1_n : cx1;
			cy2_q <= head_flags.emit ? cy2_n : cy2;
			cx2_q <= head_flags.emit ? cx2_n : cx2;
		end
	end

	// Output register: original minus opening, modulo 256
	always_ff @(posedge clk) begin
		if (adv && head_flags.emit) begin
			out_data_q <= opened ? orig + PIX_W'(1) : orig;
			out_last_q <= head_flags.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && head_flags.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`BTF_ASSERT_IMPLIES(a_ring_in_row, head_valid && !head_flags.first, WW'(k_q) < head_w, "row buffer pointer past row width")
	`BTF_ASSERT_IMPLIES(a_center_in_row, head_valid && !head_flags.first, (WW'(cx1_q) < head_w) && (WW'(cx2_q) < head_w), "window center column past row width")
	`BTF_ASSERT_NEXT(a_emit_loads_out, adv && head_flags.emit, m_tvalid && (m_tlast == $past(head_flags.last)), "emitting word did not load the output register")

endmodule

// File: hw/rtl/binary_tophat_filter_unit.sv
// Top level of the binary white top-hat filter with square mask.
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    tdata = pixel_in, tuser = op (1 = flush tick)
//  m_*      out        m_tvalid / m_tready    tdata = pixel_out, tlast = frame_last
//  cfg_*    in         cfg_we (no wait)       index 0 width, 1 height, 2 window size
//
// One word per clock is taken in steady state; every stage after the queue advances
// together, so throughput is set by the two row-buffer RAMs, each read and written
// once per word. The first 2*r*width + 2*r words of a frame give no output.
// Reset is asynchronous; it clears pointers, counters and valid flags and presets the
// config registers. Row buffers start undefined; window coordinates mask stale entries.
// A stalled output holds its word and lets up to four more input words queue.
module binary_tophat_filter_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [btf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [btf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [btf_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
	input  logic                           s_tuser,   // [0] op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [btf_pkg::PIX_W-1:0]      m_tdata,   // [7:0] pixel_out
	output logic                           m_tlast
);

	import btf_pkg::*;

	localparam int MWO         = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
	localparam int RMAX        = (MWO - 1) / 2;
	localparam int WW          = $clog2(MAX_WIDTH + 1);
	localparam int HW          = $clog2(MAX_HEIGHT + 1);
	localparam int RW          = $clog2(RMAX + 1);
	localparam int FW          = $bits(btf_flags_t);
	localparam int QW          = PIX_W + FW + WW + HW + RW;
	localparam int QUEUE_DEPTH = 4;

	btf_flags_t       push_flags, head_flags;
	logic [PIX_W-1:0] push_px, head_px;
	logic [WW-1:0]    push_w, head_w;
	logic [HW-1:0]    push_h, head_h;
	logic [RW-1:0]    push_r, head_r;
	logic             push_valid, push_ready;
	logic             head_valid, pop;
	logic [QW-1:0]    push_data, head_data;

	btf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_flags (push_flags),
		.push_px    (push_px),
		.push_w     (push_w),
		.push_h     (push_h),
		.push_r     (push_r)
	);

	// Pack the classified word for the queue
	assign push_data = {push_px, push_flags, push_w, push_h, push_r};
	assign {head_px, head_flags, head_w, head_h, head_r} = head_data;

	btf_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	btf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_flags (head_flags),
		.head_px    (head_px),
		.head_w     (head_w),
		.head_h     (head_h),
		.head_r     (head_r),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// File: dv/binary_tophat_filter_unit_tb.sv
// Self-checking testbench of the binary top-hat filter: frame stimulus against a local predictor.
`timescale 1ns / 100ps

module binary_tophat_filter_unit_tb;
	import btf_pkg::*;

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 1024;
	localparam int MAX_K      = 7;
	localparam bit OP_PIXEL   = 1'b0;
	localparam bit OP_FLUSH   = 1'b1;
	localparam int SETTLE_CYC = 64;

	typedef struct {
		logic [7:0] pix;
		logic       last;
	} tophat_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIX_W-1:0]      m_tdata;
	logic                  m_tlast;

	binary_tophat_filter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// Predictor state
	logic [7:0]  frame_px [0:MAX_W*MAX_H-1];
	logic [10:0] reg_w, reg_h;
	logic [2:0]  reg_k;
	int          pos_in, row_out, col_out, cur_w, cur_h, cur_r;

	tophat_word_t tophat_q[$];
	bit           failed;
	int           snd_idle_pct, rcv_idle_pct, stall_req, items_sent;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int clamp_dim(int v, int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int radius_of(int ws);
		int mk;
		mk = (MAX_K % 2 == 0) ? MAX_K - 1 : MAX_K;
		if (ws % 2 == 0) ws = (ws == 0) ? 1 : ws - 1;
		if (ws > mk) ws = mk;
		return (ws - 1) / 2;
	endfunction

	function automatic bit in_frame(int a, int b);
		return a >= 0 && b >= 0 && a < cur_h && b < cur_w;
	endfunction

	function automatic bit is_eroded(int a, int b);
		if (!in_frame(a, b)) return 0;
		for (int v = -cur_r; v <= cur_r; v++)
			for (int u = -cur_r; u <= cur_r; u++)
				if (!in_frame(a + v, b + u) || frame_px[(a + v) * cur_w + b + u] == 8'd0)
					return 0;
		return 1;
	endfunction

	function automatic bit is_opened(int y, int x);
		for (int v = -cur_r; v <= cur_r; v++)
			for (int u = -cur_r; u <= cur_r; u++)
				if (is_eroded(y + v, x + u)) return 1;
		return 0;
	endfunction

	// Advance the predictor by one accepted word; queue the output it causes
	function automatic void predict_tophat(bit op, logic [7:0] px);
		int total, lag, p;
		tophat_word_t w;
		if (pos_in == 0) begin
			cur_w = clamp_dim(reg_w, MAX_W);
			cur_h = clamp_dim(reg_h, MAX_H);
			cur_r = radius_of(reg_k);
		end
		total = cur_w * cur_h;
		lag = 2 * cur_r * cur_w + 2 * cur_r;
		if (pos_in < total) frame_px[pos_in] = (op == OP_PIXEL) ? px : 8'd0;
		if (pos_in < lag) begin
			pos_in++;
			return;
		end
		p = row_out * cur_w + col_out;
		w.pix = frame_px[p] - (is_opened(row_out, col_out) ? 8'd255 : 8'd0);
		w.last = (p == total - 1);
		tophat_q.push_back(w);
		if (w.last) begin
			pos_in = 0;
			row_out = 0;
			col_out = 0;
		end else begin
			pos_in++;
			col_out++;
			if (col_out >= cur_w) begin
				col_out = 0;
				row_out++;
			end
		end
	endfunction

	function automatic logic [7:0] pick_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return 8'd0;
		if (r == 4) return 8'd255;
		return 8'($urandom_range(1, 255));
	endfunction

	// Offer one word, with random idle cycles ahead of it
	task automatic send_word(bit op, logic [7:0] px);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tophat(op, px);
		items_sent++;
	endtask

	// Drop valid and hold until every output has drained
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tophat_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) reg_w = val;
		else if (idx == REG_IMAGE_HEIGHT) reg_h = val;
		else if (idx == REG_WINDOW_SIZE) reg_k = val[2:0];
	endtask

	// Configure, then push one frame of pixels and flush ticks; noise flips some ops
	task automatic run_frame(int w, int h, int k, int noise_pct);
		int total, n;
		bit op;
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, w[10:0]);
		write_reg(REG_IMAGE_HEIGHT, h[10:0]);
		write_reg(REG_WINDOW_SIZE, k[10:0]);
		@(posedge clk);
		total = clamp_dim(w[10:0], MAX_W) * clamp_dim(h[10:0], MAX_H);
		n = total + 2 * radius_of(k[2:0]) * clamp_dim(w[10:0], MAX_W) + 2 * radius_of(k[2:0]);
		for (int i = 0; i < n; i++) begin
			op = (i < total) ? OP_PIXEL : OP_FLUSH;
			if ($urandom_range(0, 99) < noise_pct) op = ~op;
			send_word(op, (op == OP_FLUSH) ? 8'($urandom) : pick_pixel());
		end
	endtask

	task automatic test_directed();
		run_frame(1, 1, 1, 0);
		run_frame(1, 1, 0, 0);
		// all-ones 3x3 frame: the opening covers everything
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, 11'd3);
		write_reg(REG_IMAGE_HEIGHT, 11'd3);
		write_reg(REG_WINDOW_SIZE, 11'd3);
		for (int i = 0; i < 9; i++) send_word(OP_PIXEL, 8'd255);
		for (int i = 0; i < 8; i++) send_word(OP_FLUSH, 8'd0);
		// early flush ticks and stray pixels past the frame
		run_frame(2, 2, 3, 50);
	endtask

	task automatic test_extremes();
		run_frame(2047, 1, 1, 0);
		run_frame(1, 1, 7, 0);
		run_frame(9, 8, 7, 3);
		run_frame(0, 0, 6, 0);
		run_frame(5, 7, 5, 0);
	endtask

	// Hold the output off long enough that the input stalls
	task automatic test_backpressure();
		wait_drained();
		stall_req = 400;
		run_frame(12, 12, 3, 0);
	endtask

	task automatic test_random(int goal);
		int start;
		start = items_sent;
		while (items_sent - start < goal) begin
			run_frame($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 7),
				($urandom_range(0, 3) == 0) ? 8 : 0);
		end
	endtask

	// Output side: random ready, long holds on request, compare each word
	initial begin : out_check
		int hold;
		tophat_word_t want;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (tophat_q.size() == 0) begin
					$display("%0t: unexpected word pix=%0d last=%0b", $time, m_tdata, m_tlast);
					failed = 1;
				end else begin
					want = tophat_q.pop_front();
					if (m_tdata !== want.pix) begin
						$display("%0t: pixel_out expected %0d actual %0d", $time, want.pix, m_tdata);
						failed = 1;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: frame_last expected %0b actual %0b", $time, want.last,
							m_tlast);
						failed = 1;
					end
				end
			end
			if (stall_req > 0) begin
				hold = stall_req;
				stall_req = 0;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	initial begin : main_seq
		failed = 0;
		stall_req = 0;
		items_sent = 0;
		snd_idle_pct = 14;
		rcv_idle_pct = 80;
		reg_w = 11'd640;
		reg_h = 11'd480;
		reg_k = 3'd3;
		pos_in = 0;
		row_out = 0;
		col_out = 0;
		cur_w = 640;
		cur_h = 480;
		cur_r = 1;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		test_directed();
		test_random(20);
		snd_idle_pct = 80;
		rcv_idle_pct = 14;
		test_extremes();
		test_random(20);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_backpressure();
		test_random(20);

		wait_drained();
		repeat (100) @(posedge clk);
		if (!failed && tophat_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/btf_pkg.sv
hw/rtl/btf_ram.sv
hw/rtl/btf_fifo.sv
hw/rtl/btf_front.sv
hw/rtl/btf_back.sv
hw/rtl/binary_tophat_filter_unit.sv
dv/binary_tophat_filter_unit_tb.sv
